>>> hw/rtl/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared widths and byte-class constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int BYTE_W  = 8;
  localparam int CP_W    = 21;
  localparam int OWED_W  = 2;
  localparam int CONT_W  = 6;

  // continuation byte detection
  localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;

  // lead byte ranges
  localparam logic [BYTE_W-1:0] ASCII_HI  = 8'h7F;
  localparam logic [BYTE_W-1:0] LEAD2_LO  = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD2_HI  = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_LO  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_HI  = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_LO  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_HI  = 8'hF4;

  // owed byte counts after a lead byte
  localparam logic [OWED_W-1:0] OWED_NONE = 2'd0;
  localparam logic [OWED_W-1:0] OWED_ONE  = 2'd1;
  localparam logic [OWED_W-1:0] OWED_TWO  = 2'd2;
  localparam logic [OWED_W-1:0] OWED_THREE = 2'd3;

endpackage

>>> hw/rtl/u8d_byte_if.sv
// ----------------------------------------------------------------------------
// u8d_byte_if
// Byte channel into the decoder: one raw byte and an end-of-string flag.
// ----------------------------------------------------------------------------
interface u8d_byte_if
  import u8d_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

>>> hw/rtl/u8d_char_if.sv
// ----------------------------------------------------------------------------
// u8d_char_if
// Code point channel out of the decoder.
// ----------------------------------------------------------------------------
interface u8d_char_if
  import u8d_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            string_done;

  modport source (output valid, output code_point, output string_done, input ready);
  modport sink   (input valid, input code_point, input string_done, output ready);
endinterface

>>> hw/rtl/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Decodes a UTF-8 byte stream into code points, one byte per request.
// ----------------------------------------------------------------------------
// A code point appears on char_chan in the cycle after its final byte is accepted.
// Throughput: one byte per cycle while char_chan is not stalled; the single result
// register is the only stage, and it refills in the same cycle it is drained.
// Reset: rst clears the owed count, the accumulator and the result valid.
module utf8_stream_decoder
  import u8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  u8d_byte_if.sink   byte_chan,
  u8d_char_if.source char_chan
);

  logic [OWED_W-1:0] bytes_owed;
  logic [OWED_W-1:0] bytes_owed_next;
  logic [CP_W-1:0]   accumulator;
  logic [CP_W-1:0]   accumulator_next;
  logic              out_valid;
  logic [CP_W-1:0]   code_point;
  logic              string_done;

  logic              in_accept;
  logic              emit;
  logic              is_cont;
  logic [OWED_W-1:0] owed_dec;

  // take a byte whenever the result register is empty or being drained
  assign byte_chan.ready = !out_valid || char_chan.ready;
  assign in_accept       = byte_chan.valid && byte_chan.ready;

  assign is_cont  = (byte_chan.byte_value & CONT_MASK) == CONT_TAG;
  assign owed_dec = bytes_owed - OWED_ONE;

  // next decoder state and emit decision for the incoming byte
  always_comb begin
    bytes_owed_next  = bytes_owed;
    accumulator_next = accumulator;
    emit             = 1'b0;
    if (bytes_owed != OWED_NONE) begin
      if (is_cont) begin
        accumulator_next = {accumulator[CP_W-CONT_W-1:0], byte_chan.byte_value[CONT_W-1:0]};
      end
      bytes_owed_next = owed_dec;
      emit            = (owed_dec == OWED_NONE);
    end else begin
      unique case (byte_chan.byte_value) inside
        [8'h00:ASCII_HI]: begin
          accumulator_next = CP_W'(byte_chan.byte_value);
          emit             = 1'b1;
        end
        [LEAD2_LO:LEAD2_HI]: begin
          accumulator_next = CP_W'(byte_chan.byte_value[4:0]);
          bytes_owed_next  = OWED_ONE;
        end
        [LEAD3_LO:LEAD3_HI]: begin
          accumulator_next = CP_W'(byte_chan.byte_value[3:0]);
          bytes_owed_next  = OWED_TWO;
        end
        [LEAD4_LO:LEAD4_HI]: begin
          accumulator_next = CP_W'(byte_chan.byte_value[2:0]);
          bytes_owed_next  = OWED_THREE;
        end
        default: begin
          // invalid lead byte, dropped
        end
      endcase
    end
  end

  // decoder state, cleared at the end of each string
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_owed  <= OWED_NONE;
      accumulator <= '0;
    end else if (in_accept) begin
      if (byte_chan.last_byte) begin
        bytes_owed  <= OWED_NONE;
        accumulator <= '0;
      end else begin
        bytes_owed  <= bytes_owed_next;
        accumulator <= accumulator_next;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (byte_chan.ready) begin
      out_valid <= in_accept && emit;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      code_point  <= accumulator_next;
      string_done <= byte_chan.last_byte;
    end
  end

  assign char_chan.valid       = out_valid;
  assign char_chan.code_point  = code_point;
  assign char_chan.string_done = string_done;

  // an empty result register never holds off the byte side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> byte_chan.ready)
    else $error("byte channel stalled with empty result register");

  // end of string leaves the decoder idle
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    in_accept && byte_chan.last_byte |=> bytes_owed == OWED_NONE && accumulator == '0)
    else $error("state not cleared after last byte");

  // a new result only follows an accepted byte
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_accept))
    else $error("result appeared without an accepted byte");

  // ascii outside a sequence passes straight through
  a_ascii_pass: assert property (@(posedge clk) disable iff (rst)
    in_accept && bytes_owed == OWED_NONE && byte_chan.byte_value <= ASCII_HI
    |=> out_valid && code_point == CP_W'($past(byte_chan.byte_value)))
    else $error("ascii byte not emitted unchanged");

endmodule
